// ----- rtl/core/sdis_pkg.sv -----
// Shared types and constants for the SD init/erase command sequencer.
// No dependencies.
package sdis_pkg;

  localparam int PhaseWidth = 4;

  // Sequencer phases (the command that is pending)
  localparam logic [PhaseWidth-1:0] PH_IDLE   = 4'd0;
  localparam logic [PhaseWidth-1:0] PH_CMD0   = 4'd1;
  localparam logic [PhaseWidth-1:0] PH_CMD8   = 4'd2;
  localparam logic [PhaseWidth-1:0] PH_CMD55  = 4'd3;
  localparam logic [PhaseWidth-1:0] PH_ACMD41 = 4'd4;
  localparam logic [PhaseWidth-1:0] PH_CMD1   = 4'd5;
  localparam logic [PhaseWidth-1:0] PH_CMD2   = 4'd6;
  localparam logic [PhaseWidth-1:0] PH_CMD3   = 4'd7;
  localparam logic [PhaseWidth-1:0] PH_CMD9   = 4'd8;
  localparam logic [PhaseWidth-1:0] PH_CMD7   = 4'd9;
  localparam logic [PhaseWidth-1:0] PH_CMD32  = 4'd10;
  localparam logic [PhaseWidth-1:0] PH_CMD33  = 4'd11;
  localparam logic [PhaseWidth-1:0] PH_CMD38  = 4'd12;
  localparam logic [PhaseWidth-1:0] PH_CMD13  = 4'd13;

  // Request opcodes
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Bus event kinds
  localparam logic [1:0] EV_SENT    = 2'd0;
  localparam logic [1:0] EV_RESP    = 2'd1;
  localparam logic [1:0] EV_CRCFAIL = 2'd2;
  localparam logic [1:0] EV_TIMEOUT = 2'd3;

  // Response types
  localparam logic [1:0] RSP_NONE  = 2'd0;
  localparam logic [1:0] RSP_SHORT = 2'd1;
  localparam logic [1:0] RSP_LONG  = 2'd2;

  // Result kinds
  localparam logic [1:0] RES_ISSUE = 2'd0;
  localparam logic [1:0] RES_OK    = 2'd1;
  localparam logic [1:0] RES_FAIL  = 2'd2;

  // Failure codes
  localparam logic [2:0] FAIL_NONE      = 3'd0;
  localparam logic [2:0] FAIL_CMD0      = 3'd1;
  localparam logic [2:0] FAIL_PATTERN   = 3'd2;
  localparam logic [2:0] FAIL_RETRIES   = 3'd3;
  localparam logic [2:0] FAIL_MMC       = 3'd4;

  // Card kinds
  localparam logic [1:0] CARD_UNKNOWN = 2'd0;
  localparam logic [1:0] CARD_SDSC    = 2'd1;
  localparam logic [1:0] CARD_SDHC    = 2'd2;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
  localparam logic [5:0] CMD_SEND_OP     = 6'd1;
  localparam logic [5:0] CMD_ALL_CID     = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
  localparam logic [5:0] CMD_SELECT      = 6'd7;
  localparam logic [5:0] CMD_IF_COND     = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
  localparam logic [5:0] CMD_STATUS      = 6'd13;
  localparam logic [5:0] CMD_ERASE_START = 6'd32;
  localparam logic [5:0] CMD_ERASE_END   = 6'd33;
  localparam logic [5:0] CMD_ERASE       = 6'd38;
  localparam logic [5:0] ACMD_SD_OP      = 6'd41;
  localparam logic [5:0] CMD_APP         = 6'd55;

  // Arguments and reset values
  localparam logic [31:0] CHECK_PATTERN = 32'h0000_01AA;
  localparam logic [31:0] ACMD41_ARG    = 32'h8010_0000 | 32'h4000_0000;
  localparam logic [31:0] CMD1_ARG      = 32'h80FF_8000;
  localparam logic [15:0] RETRY_LIMIT_RESET = 16'hFFFF;
  localparam int          OCR_BUSY_BIT  = 31;
  localparam int          OCR_CCS_BIT   = 30;
  localparam int          STATUS_READY_BIT = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  index;
    logic [31:0] argument;
    logic [1:0]  rsp;
    logic [1:0]  card_kind;
    logic [15:0] rel_addr;
    logic [2:0]  failure;
    logic [31:0] ocr;
  } result_t;

endpackage

// ----- rtl/core/sd_card_init_erase_sequencer.sv -----
// SD host command sequencer: card init (CMD0/8/55/41/1/2/3/9/7) and erase (CMD32/33/38/13).
// Depends on sdis_pkg.
// A result beat is registered: it lands in the output register, or in the skid while that is held.
// Throughput: one input beat per cycle while the skid is empty; the state step is a single registered transition.
// A two-deep output (result register plus skid) keeps input open while a result waits.
// Reset (rst, synchronous): phase idle, card state zero, retry limit 0xFFFF, output empty.
module sd_card_init_erase_sequencer
  import sdis_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write_enable,
  input  logic [15:0] cfg_write_data,
  // request / event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [1:0]  event_kind,
  input  logic [31:0] response_word,
  input  logic [31:0] first_sector,
  input  logic [31:0] last_sector,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [5:0]  command_index,
  output logic [31:0] command_argument,
  output logic [1:0]  expected_response,
  output logic [1:0]  card_kind,
  output logic [15:0] relative_address,
  output logic [2:0]  failure_code,
  output logic [31:0] operating_conditions
);

  // Sequencer state
  logic [PhaseWidth-1:0] phase, phase_next;
  logic [15:0] retries_left, retries_left_next;
  logic [1:0]  card_kind_reg, card_kind_reg_next;
  logic [15:0] card_address_reg, card_address_reg_next;
  logic [31:0] ocr_reg, ocr_reg_next;
  logic [31:0] pending_last_sector, pending_last_sector_next;
  logic [15:0] retry_limit;

  // Output stage: result register and skid
  result_t out_data, skid_data;
  logic    skid_valid;

  // Step result
  result_t res;
  logic    res_valid;
  logic    in_accept, out_take;
  logic    got_resp;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid & ~skid_valid;
  assign out_take  = out_valid & ~out_stall;
  assign got_resp  = (event_kind == EV_RESP) || (event_kind == EV_CRCFAIL);

  // One step of the sequencer. is_cmd, is_fin, c_* and f_code collect what the step emits;
  // the card fields of the result carry the updated register values.
  always_comb begin
    logic       is_cmd;
    logic       is_fin;
    logic [5:0]  c_idx;
    logic [31:0] c_arg;
    logic [1:0]  c_rsp;
    logic [2:0]  f_code;
    logic        do_repoll;
    logic [PhaseWidth-1:0] rp_phase;
    logic [5:0]  rp_idx;
    logic [31:0] rp_arg;

    phase_next               = phase;
    retries_left_next        = retries_left;
    card_kind_reg_next       = card_kind_reg;
    card_address_reg_next    = card_address_reg;
    ocr_reg_next             = ocr_reg;
    pending_last_sector_next = pending_last_sector;
    is_cmd    = 1'b0;
    is_fin    = 1'b0;
    c_idx     = CMD_GO_IDLE;
    c_arg     = '0;
    c_rsp     = RSP_NONE;
    f_code    = FAIL_NONE;
    do_repoll = 1'b0;
    rp_phase  = PH_CMD55;
    rp_idx    = CMD_APP;
    rp_arg    = '0;

    case (opcode)
      OP_INIT: begin
        card_kind_reg_next = CARD_UNKNOWN;
        retries_left_next  = '0;
        phase_next = PH_CMD0;
        is_cmd = 1'b1;
        c_idx  = CMD_GO_IDLE;
        c_rsp  = RSP_NONE;
      end
      OP_ERASE: begin
        pending_last_sector_next = last_sector;
        phase_next = PH_CMD32;
        is_cmd = 1'b1;
        c_idx  = CMD_ERASE_START;
        c_arg  = first_sector;
        c_rsp  = RSP_SHORT;
      end
      OP_EVENT: begin
        if (phase == PH_CMD0) begin
          if (event_kind == EV_SENT) begin
            phase_next = PH_CMD8;
            is_cmd = 1'b1;
            c_idx  = CMD_IF_COND;
            c_arg  = CHECK_PATTERN;
            c_rsp  = RSP_SHORT;
          end else if (event_kind == EV_TIMEOUT) begin
            is_fin = 1'b1;
            f_code = FAIL_CMD0;
          end
        end else if (phase != PH_IDLE && event_kind != EV_SENT) begin
          case (phase)
            PH_CMD8: begin
              retries_left_next = retry_limit;
              if (event_kind == EV_RESP) begin
                card_kind_reg_next = CARD_SDSC;
                if (response_word != CHECK_PATTERN) begin
                  is_fin = 1'b1;
                  f_code = FAIL_PATTERN;
                end else begin
                  phase_next = PH_CMD55;
                  is_cmd = 1'b1;
                  c_idx  = CMD_APP;
                  c_rsp  = RSP_SHORT;
                end
              end else begin
                phase_next = PH_CMD1;
                is_cmd = 1'b1;
                c_idx  = CMD_SEND_OP;
                c_arg  = CMD1_ARG;
                c_rsp  = RSP_SHORT;
              end
            end
            PH_CMD55: begin
              if (event_kind == EV_RESP) begin
                phase_next = PH_ACMD41;
                is_cmd = 1'b1;
                c_idx  = ACMD_SD_OP;
                c_arg  = ACMD41_ARG;
                c_rsp  = RSP_SHORT;
              end else begin
                do_repoll = 1'b1;
              end
            end
            PH_ACMD41: begin
              if (got_resp) begin
                ocr_reg_next = response_word;
              end
              if (got_resp && response_word[OCR_BUSY_BIT]) begin
                card_kind_reg_next = response_word[OCR_CCS_BIT] ? CARD_SDHC : CARD_SDSC;
                phase_next = PH_CMD2;
                is_cmd = 1'b1;
                c_idx  = CMD_ALL_CID;
                c_rsp  = RSP_LONG;
              end else begin
                do_repoll = 1'b1;
              end
            end
            PH_CMD1: begin
              if (event_kind != EV_RESP) begin
                is_fin = 1'b1;
                f_code = FAIL_RETRIES;
              end else if (response_word[OCR_BUSY_BIT]) begin
                is_fin = 1'b1;
                f_code = FAIL_MMC;
              end else begin
                do_repoll = 1'b1;
                rp_phase  = PH_CMD1;
                rp_idx    = CMD_SEND_OP;
                rp_arg    = CMD1_ARG;
              end
            end
            PH_CMD2: begin
              phase_next = PH_CMD3;
              is_cmd = 1'b1;
              c_idx  = CMD_SEND_RCA;
              c_rsp  = RSP_SHORT;
            end
            PH_CMD3: begin
              if (got_resp) begin
                card_address_reg_next = response_word[31:16];
              end
              phase_next = PH_CMD9;
              is_cmd = 1'b1;
              c_idx  = CMD_SEND_CSD;
              c_arg  = {card_address_reg_next, 16'h0000};
              c_rsp  = RSP_LONG;
            end
            PH_CMD9: begin
              phase_next = PH_CMD7;
              is_cmd = 1'b1;
              c_idx  = CMD_SELECT;
              c_arg  = {card_address_reg, 16'h0000};
              c_rsp  = RSP_SHORT;
            end
            PH_CMD7: begin
              is_fin = 1'b1;
            end
            PH_CMD32: begin
              phase_next = PH_CMD33;
              is_cmd = 1'b1;
              c_idx  = CMD_ERASE_END;
              c_arg  = pending_last_sector;
              c_rsp  = RSP_SHORT;
            end
            PH_CMD33: begin
              phase_next = PH_CMD38;
              is_cmd = 1'b1;
              c_idx  = CMD_ERASE;
              c_rsp  = RSP_SHORT;
            end
            PH_CMD38: begin
              phase_next = PH_CMD13;
              is_cmd = 1'b1;
              c_idx  = CMD_STATUS;
              c_arg  = {card_address_reg, 16'h0000};
              c_rsp  = RSP_SHORT;
            end
            PH_CMD13: begin
              if (got_resp && response_word[STATUS_READY_BIT]) begin
                is_fin = 1'b1;
              end else begin
                phase_next = PH_CMD13;
                is_cmd = 1'b1;
                c_idx  = CMD_STATUS;
                c_arg  = {card_address_reg, 16'h0000};
                c_rsp  = RSP_SHORT;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
      end
      default: begin
        // unused opcode: no effect
      end
    endcase

    // Poll again while retries remain, else power-up fails
    if (do_repoll) begin
      if (retries_left == '0) begin
        is_fin = 1'b1;
        f_code = FAIL_RETRIES;
      end else begin
        retries_left_next = retries_left - 16'd1;
        phase_next = rp_phase;
        is_cmd = 1'b1;
        c_idx  = rp_idx;
        c_arg  = rp_arg;
        c_rsp  = RSP_SHORT;
      end
    end

    if (is_fin) begin
      phase_next = PH_IDLE;
    end

    res_valid     = is_cmd | is_fin;
    res.kind      = is_cmd ? RES_ISSUE : ((f_code != FAIL_NONE) ? RES_FAIL : RES_OK);
    res.index     = is_cmd ? c_idx : CMD_GO_IDLE;
    res.argument  = is_cmd ? c_arg : '0;
    res.rsp       = is_cmd ? c_rsp : RSP_NONE;
    res.card_kind = card_kind_reg_next;
    res.rel_addr  = card_address_reg_next;
    res.failure   = is_cmd ? FAIL_NONE : f_code;
    res.ocr       = ocr_reg_next;
  end

  // Config register and sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit         <= RETRY_LIMIT_RESET;
      phase               <= PH_IDLE;
      retries_left        <= '0;
      card_kind_reg       <= CARD_UNKNOWN;
      card_address_reg    <= '0;
      ocr_reg             <= '0;
      pending_last_sector <= '0;
    end else begin
      if (cfg_write_enable) begin
        retry_limit <= cfg_write_data;
      end
      if (in_accept) begin
        phase               <= phase_next;
        retries_left        <= retries_left_next;
        card_kind_reg       <= card_kind_reg_next;
        card_address_reg    <= card_address_reg_next;
        ocr_reg             <= ocr_reg_next;
        pending_last_sector <= pending_last_sector_next;
      end
    end
  end

  // Output register with skid. Input is open only while the skid is empty,
  // so a new result lands in the output register when it frees up, else in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= in_accept & res_valid;
    end else if (in_accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || out_take) begin
      out_data <= res;
    end else begin
      skid_data <= res;
    end
  end

  assign result_kind          = out_data.kind;
  assign command_index        = out_data.index;
  assign command_argument     = out_data.argument;
  assign expected_response    = out_data.rsp;
  assign card_kind            = out_data.card_kind;
  assign relative_address     = out_data.rel_addr;
  assign failure_code         = out_data.failure;
  assign operating_conditions = out_data.ocr;

endmodule

// ----- tb/sd_card_init_erase_sequencer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the SD init/erase command sequencer: a directed table, then
// state-aware random bus traffic, every result beat checked against an in-bench model.
// Depends on sdis_pkg and rtl/core/sd_card_init_erase_sequencer.sv.
module sd_card_init_erase_sequencer_tb;
  import sdis_pkg::*;

  // Opcode the block must drop without a result
  localparam logic [1:0] OP_IGNORED = 2'd3;
  // Cycles with no beat on either channel before the run is declared hung
  localparam int STUCK_LIMIT = 5000;
  // Result beat is registered after its input beat; the skid can hold it back further
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEMS_PER_PHASE = 104;
  // OCR used on the directed path: power-up done, high capacity
  localparam logic [31:0] DIR_OCR = 32'hC0FF_8000;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  ev;
    logic [31:0] rw;
    logic [31:0] fs;
    logic [31:0] ls;
  } bus_req_t;

  typedef struct {
    bit          is_cfg;
    logic [15:0] limit;
    bus_req_t    req;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [1:0]  event_kind = '0;
  logic [31:0] response_word = '0;
  logic [31:0] first_sector = '0;
  logic [31:0] last_sector = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [5:0]  command_index;
  logic [31:0] command_argument;
  logic [1:0]  expected_response;
  logic [1:0]  card_kind;
  logic [15:0] relative_address;
  logic [2:0]  failure_code;
  logic [31:0] operating_conditions;

  // Directed rows may carry a hand-typed result that replaces the model's one
  bit          typed_row = 1'b0;
  result_t     typed_want = '0;

  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          mismatches = 0;
  int          stuck_cycles = 0;

  result_t     expected_results[$];
  dir_row_t    dir_rows[$];

  // Sequencer model state, mirrors the block after reset
  logic [PhaseWidth-1:0] seq_phase = PH_IDLE;
  logic [15:0] polls_left = '0;
  logic [1:0]  card_kind_q = CARD_UNKNOWN;
  logic [15:0] rca_q = '0;
  logic [31:0] ocr_q = '0;
  logic [31:0] erase_end_q = '0;
  logic [15:0] retry_limit_q = RETRY_LIMIT_RESET;

  sd_card_init_erase_sequencer dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_write_enable     (cfg_write_enable),
    .cfg_write_data       (cfg_write_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .opcode               (opcode),
    .event_kind           (event_kind),
    .response_word        (response_word),
    .first_sector         (first_sector),
    .last_sector          (last_sector),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .result_kind          (result_kind),
    .command_index        (command_index),
    .command_argument     (command_argument),
    .expected_response    (expected_response),
    .card_kind            (card_kind),
    .relative_address     (relative_address),
    .failure_code         (failure_code),
    .operating_conditions (operating_conditions)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sequencer model
  // ---------------------------------------------------------------------------

  // Card fields are taken after any update made by the same step
  function automatic result_t issue_cmd(logic [PhaseWidth-1:0] next, logic [5:0] idx,
                                        logic [31:0] arg, logic [1:0] rsp);
    seq_phase = next;
    return {RES_ISSUE, idx, arg, rsp, card_kind_q, rca_q, FAIL_NONE, ocr_q};
  endfunction

  function automatic result_t end_seq(logic [2:0] fail);
    seq_phase = PH_IDLE;
    return {(fail == FAIL_NONE) ? RES_OK : RES_FAIL, 6'd0, 32'd0, RSP_NONE,
            card_kind_q, rca_q, fail, ocr_q};
  endfunction

  // Power-up poll: another try while any are left, else give up
  function automatic result_t repoll(logic [PhaseWidth-1:0] next, logic [5:0] idx,
                                     logic [31:0] arg);
    if (polls_left == '0) return end_seq(FAIL_RETRIES);
    polls_left = polls_left - 16'd1;
    return issue_cmd(next, idx, arg, RSP_SHORT);
  endfunction

  // One accepted beat; returns 1 when it causes a result
  function automatic bit predict_beat(input bus_req_t q, output result_t r);
    bit got;
    got = (q.ev == EV_RESP) || (q.ev == EV_CRCFAIL);
    predict_beat = 1'b1;
    r = '0;
    if (q.op == OP_INIT) begin
      card_kind_q = CARD_UNKNOWN;
      polls_left = '0;
      r = issue_cmd(PH_CMD0, CMD_GO_IDLE, '0, RSP_NONE);
    end else if (q.op == OP_ERASE) begin
      erase_end_q = q.ls;
      r = issue_cmd(PH_CMD32, CMD_ERASE_START, q.fs, RSP_SHORT);
    end else if (q.op != OP_EVENT || seq_phase == PH_IDLE) begin
      predict_beat = 1'b0;
    end else if (seq_phase == PH_CMD0) begin
      // CMD0 has no response: only sent or timeout matter
      if (q.ev == EV_SENT) r = issue_cmd(PH_CMD8, CMD_IF_COND, CHECK_PATTERN, RSP_SHORT);
      else if (q.ev == EV_TIMEOUT) r = end_seq(FAIL_CMD0);
      else predict_beat = 1'b0;
    end else if (q.ev == EV_SENT) begin
      predict_beat = 1'b0;
    end else begin
      case (seq_phase)
        PH_CMD8: begin
          polls_left = retry_limit_q;
          if (q.ev == EV_RESP) begin
            card_kind_q = CARD_SDSC;
            if (q.rw != CHECK_PATTERN) r = end_seq(FAIL_PATTERN);
            else r = issue_cmd(PH_CMD55, CMD_APP, '0, RSP_SHORT);
          end else begin
            // no clean echo: treat as MMC and poll CMD1
            r = issue_cmd(PH_CMD1, CMD_SEND_OP, CMD1_ARG, RSP_SHORT);
          end
        end
        PH_CMD55: begin
          if (q.ev == EV_RESP) r = issue_cmd(PH_ACMD41, ACMD_SD_OP, ACMD41_ARG, RSP_SHORT);
          else r = repoll(PH_CMD55, CMD_APP, '0);
        end
        PH_ACMD41: begin
          if (got) ocr_q = q.rw;
          if (got && q.rw[OCR_BUSY_BIT]) begin
            card_kind_q = q.rw[OCR_CCS_BIT] ? CARD_SDHC : CARD_SDSC;
            r = issue_cmd(PH_CMD2, CMD_ALL_CID, '0, RSP_LONG);
          end else begin
            r = repoll(PH_CMD55, CMD_APP, '0);
          end
        end
        PH_CMD1: begin
          if (q.ev != EV_RESP) r = end_seq(FAIL_RETRIES);
          else if (q.rw[OCR_BUSY_BIT]) r = end_seq(FAIL_MMC);
          else r = repoll(PH_CMD1, CMD_SEND_OP, CMD1_ARG);
        end
        PH_CMD2: r = issue_cmd(PH_CMD3, CMD_SEND_RCA, '0, RSP_SHORT);
        PH_CMD3: begin
          if (got) rca_q = q.rw[31:16];
          r = issue_cmd(PH_CMD9, CMD_SEND_CSD, {rca_q, 16'h0000}, RSP_LONG);
        end
        PH_CMD9:  r = issue_cmd(PH_CMD7, CMD_SELECT, {rca_q, 16'h0000}, RSP_SHORT);
        PH_CMD7:  r = end_seq(FAIL_NONE);
        PH_CMD32: r = issue_cmd(PH_CMD33, CMD_ERASE_END, erase_end_q, RSP_SHORT);
        PH_CMD33: r = issue_cmd(PH_CMD38, CMD_ERASE, '0, RSP_SHORT);
        PH_CMD38: r = issue_cmd(PH_CMD13, CMD_STATUS, {rca_q, 16'h0000}, RSP_SHORT);
        PH_CMD13: begin
          if (got && q.rw[STATUS_READY_BIT]) r = end_seq(FAIL_NONE);
          else r = issue_cmd(PH_CMD13, CMD_STATUS, {rca_q, 16'h0000}, RSP_SHORT);
        end
        default: begin
          seq_phase = PH_IDLE;
          predict_beat = 1'b0;
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic result_t outcome(logic [1:0] kind, logic [5:0] idx, logic [31:0] arg,
                                      logic [1:0] rsp, logic [1:0] ck, logic [15:0] rca,
                                      logic [2:0] fail, logic [31:0] ocr);
    return {kind, idx, arg, rsp, ck, rca, fail, ocr};
  endfunction

  task automatic add_req(logic [1:0] op, logic [1:0] ev, logic [31:0] rw,
                         logic [31:0] fs, logic [31:0] ls);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.limit = '0;
    r.req = {op, ev, rw, fs, ls};
    r.typed = 1'b0;
    r.want = '0;
    dir_rows.push_back(r);
  endtask

  task automatic add_checked(logic [1:0] op, logic [1:0] ev, logic [31:0] rw, result_t want);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.limit = '0;
    r.req = {op, ev, rw, 32'd0, 32'd0};
    r.typed = 1'b1;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // Random beat shaped by where the model says the sequence is, so most
  // traffic walks real init/erase flows; the rest is noise and restarts.
  function automatic bus_req_t next_req();
    bus_req_t q;
    int roll;
    q.rw = $urandom;
    q.fs = $urandom;
    q.ls = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      q.op = 2'($urandom_range(0, 3));
      q.ev = 2'($urandom_range(0, 3));
      return q;
    end
    q.op = OP_EVENT;
    roll = $urandom_range(0, 99);
    if (roll < 10) q.ev = EV_SENT;
    else if (roll < 70) q.ev = EV_RESP;
    else if (roll < 85) q.ev = EV_CRCFAIL;
    else q.ev = EV_TIMEOUT;
    case (seq_phase)
      PH_IDLE:   q.op = ($urandom_range(0, 99) < 65) ? OP_INIT : OP_ERASE;
      PH_CMD0:   q.ev = ($urandom_range(0, 99) < 88) ? EV_SENT : EV_TIMEOUT;
      PH_CMD8:   if ($urandom_range(0, 99) < 85) q.rw = CHECK_PATTERN;
      PH_ACMD41: q.rw[OCR_BUSY_BIT] = ($urandom_range(0, 99) < 35);
      PH_CMD1:   q.rw[OCR_BUSY_BIT] = ($urandom_range(0, 99) < 20);
      PH_CMD13:  q.rw[STATUS_READY_BIT] = ($urandom_range(0, 99) < 40);
      default: ;
    endcase
    // occasional new request on top of a running sequence
    if (seq_phase != PH_IDLE && $urandom_range(0, 99) < 3)
      q.op = ($urandom_range(0, 1) == 0) ? OP_INIT : OP_ERASE;
    return q;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic drive_beat(input bus_req_t q, input bit typed, input result_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= q.op;
    event_kind    <= q.ev;
    response_word <= q.rw;
    first_sector  <= q.fs;
    last_sector   <= q.ls;
    typed_row     <= typed;
    typed_want    <= want;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Hold off input until every expected beat is back and the pipe has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] limit);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= limit;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall: redrawn every cycle at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

  // ---------------------------------------------------------------------------
  // Scoreboard: check the result beat first (it belongs to an older input beat),
  // then step the model on the input beat taken at this same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    result_t  got;
    result_t  want;
    result_t  predicted;
    bus_req_t q;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {result_kind, command_index, command_argument, expected_response,
               card_kind, relative_address, failure_code, operating_conditions};
        if (expected_results.size() == 0) begin
          $error("result beat with nothing pending: kind 0x%0h index %0d",
                 result_kind, command_index);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.kind, got.kind);
          check_field("command_index", want.index, got.index);
          check_field("command_argument", want.argument, got.argument);
          check_field("expected_response", want.rsp, got.rsp);
          check_field("card_kind", want.card_kind, got.card_kind);
          check_field("relative_address", want.rel_addr, got.rel_addr);
          check_field("failure_code", want.failure, got.failure);
          check_field("operating_conditions", want.ocr, got.ocr);
        end
      end
      if (in_valid && !in_stall) begin
        q = {opcode, event_kind, response_word, first_sector, last_sector};
        if (predict_beat(q, predicted)) begin
          expected_results.push_back(typed_row ? typed_want : predicted);
        end
      end
      if (cfg_write_enable) retry_limit_q = cfg_write_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no beat on either channel for too long means the block hung
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    cfg_row;
    int          idle_pcts[4]  = '{0, 71, 0, 10};
    int          stall_pcts[4] = '{0, 0, 71, 10};
    logic [15:0] limits[4]     = '{16'hFFFF, 16'h0000, 16'h0002, 16'h0001};

    // Directed table. Retry limit stays at its reset value for the first block.
    // Init after reset: CMD0, everything else zero.
    add_checked(OP_INIT, EV_SENT, '0, outcome(RES_ISSUE, CMD_GO_IDLE, '0, RSP_NONE,
                CARD_UNKNOWN, '0, FAIL_NONE, '0));
    // CMD0 never went out on the bus
    add_checked(OP_EVENT, EV_TIMEOUT, '0, outcome(RES_FAIL, 6'd0, '0, RSP_NONE,
                CARD_UNKNOWN, '0, FAIL_CMD0, '0));
    add_req(OP_EVENT, EV_RESP, 32'hFFFF_FFFF, '0, '0);      // event while idle: dropped
    add_req(OP_IGNORED, EV_RESP, '0, 32'hFFFF_FFFF, '0);   // unused opcode: dropped
    add_req(OP_INIT, EV_SENT, '0, '0, '0);
    add_req(OP_EVENT, EV_RESP, '0, '0, '0);                 // response during CMD0: dropped
    add_req(OP_EVENT, EV_SENT, '0, '0, '0);                 // -> CMD8
    add_req(OP_EVENT, EV_SENT, '0, '0, '0);                 // sent while awaiting response
    add_req(OP_EVENT, EV_RESP, CHECK_PATTERN, '0, '0);      // echo ok -> CMD55
    add_req(OP_EVENT, EV_TIMEOUT, '0, '0, '0);              // CMD55 unanswered: one poll used
    add_req(OP_EVENT, EV_RESP, '0, '0, '0);                 // -> ACMD41
    add_req(OP_EVENT, EV_TIMEOUT, '0, '0, '0);              // ACMD41 timeout, OCR kept
    add_req(OP_EVENT, EV_RESP, '0, '0, '0);
    add_req(OP_EVENT, EV_CRCFAIL, DIR_OCR, '0, '0);         // CRC bad but word still used
    add_req(OP_EVENT, EV_TIMEOUT, '0, '0, '0);              // CMD2 timeout goes on
    add_req(OP_EVENT, EV_CRCFAIL, 32'hFFFF_0000, '0, '0);   // RCA 0xFFFF
    add_req(OP_EVENT, EV_RESP, '0, '0, '0);                 // -> CMD7
    add_checked(OP_EVENT, EV_RESP, '0, outcome(RES_OK, 6'd0, '0, RSP_NONE,
                CARD_SDHC, 16'hFFFF, FAIL_NONE, DIR_OCR));
    add_req(OP_ERASE, EV_SENT, '0, 32'h0000_0000, 32'hFFFF_FFFF);
    add_req(OP_ERASE, EV_SENT, '0, 32'hFFFF_FFFF, 32'h0000_0000); // restart while busy
    add_req(OP_EVENT, EV_RESP, '0, '0, '0);                 // -> CMD33
    add_req(OP_EVENT, EV_RESP, '0, '0, '0);                 // -> CMD38
    add_req(OP_EVENT, EV_TIMEOUT, '0, '0, '0);              // -> CMD13
    add_req(OP_EVENT, EV_CRCFAIL, 32'h0000_0100, '0, '0);   // ready bit -> done
    // No retries from here on
    cfg_row.is_cfg = 1'b1;
    cfg_row.limit = 16'h0000;
    cfg_row.req = '0;
    cfg_row.typed = 1'b0;
    cfg_row.want = '0;
    dir_rows.push_back(cfg_row);
    add_req(OP_INIT, EV_SENT, '0, '0, '0);
    add_req(OP_EVENT, EV_SENT, '0, '0, '0);
    add_checked(OP_EVENT, EV_RESP, 32'h0000_01AB, outcome(RES_FAIL, 6'd0, '0, RSP_NONE,
                CARD_SDSC, 16'hFFFF, FAIL_PATTERN, DIR_OCR));
    add_req(OP_INIT, EV_SENT, '0, '0, '0);
    add_req(OP_EVENT, EV_SENT, '0, '0, '0);
    add_req(OP_EVENT, EV_TIMEOUT, '0, '0, '0);              // no CMD8 answer -> CMD1
    add_checked(OP_EVENT, EV_RESP, '0, outcome(RES_FAIL, 6'd0, '0, RSP_NONE,
                CARD_UNKNOWN, 16'hFFFF, FAIL_RETRIES, DIR_OCR));
    add_req(OP_INIT, EV_SENT, '0, '0, '0);
    add_req(OP_EVENT, EV_SENT, '0, '0, '0);
    add_req(OP_EVENT, EV_CRCFAIL, '0, '0, '0);              // -> CMD1
    add_checked(OP_EVENT, EV_RESP, 32'h8000_0000, outcome(RES_FAIL, 6'd0, '0, RSP_NONE,
                CARD_UNKNOWN, 16'hFFFF, FAIL_MMC, DIR_OCR));

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_limit(dir_rows[i].limit);
      end else begin
        drive_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: each changes the retry limit while idle, then runs with
    // its own mix of sender gaps and receiver stalls.
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_limit(limits[p]);
      sender_idle_pct = idle_pcts[p];
      receiver_stall_pct = stall_pcts[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 199) == 0) wait_idle();   // let the output run dry
        drive_beat(next_req(), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sdis_pkg.sv
rtl/core/sd_card_init_erase_sequencer.sv
tb/sd_card_init_erase_sequencer_tb.sv
